### design/pixel_to_world_polar_map_core_macros.svh
// Assertion helpers for the polar map core.
`ifndef PIXEL_TO_WORLD_POLAR_MAP_CORE_MACROS_SVH
`define PIXEL_TO_WORLD_POLAR_MAP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PWPM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PWPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PWPM_ASSERT_SAME(label, clk, rst, ante, cons)
`define PWPM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/pwpm_pkg.sv
package pwpm_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OUT_BOUND = 2'd1,
      ST_ZERO_RNG  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_WIDTH    = 2'd0,
      CSR_HEIGHT   = 2'd1,
      CSR_CENTER_C = 2'd2,
      CSR_CENTER_R = 2'd3
   } csr_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DECODE, S_SWEEP, S_READ, S_PREP, S_ITER, S_FINISH, S_RESP
   } state_type;

   typedef struct packed {
      logic load_req;
      logic sweep_start;
      logic sweep_step;
      logic prep;
      logic iter;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic quick;
      logic iter_last;
      logic sweep_last;
   } dp_stat_type;

   localparam logic [29:0] CORDIC_GAIN = 30'd652032874;
   localparam logic signed [17:0] PI_Q13 = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
   localparam logic signed [20:0] HALF_Q16 = 21'sd102944;
   localparam logic signed [20:0] FULL_Q16 = 21'sd205888;
   localparam logic signed [33:0] POS_MAX = 34'sd8388607;
   localparam logic signed [33:0] POS_MIN = -34'sd8388608;
   localparam logic [12:0] DIST_ALL_ONES = 13'h1FFF;
   localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
   localparam logic [3:0] SQRT_LAST = 4'd12;
   localparam logic [3:0] CORDIC_LAST = 4'd15;

   function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
      logic signed [19:0] a;
      case (i)
         4'd0:    a = 20'sd51472;
         4'd1:    a = 20'sd30386;
         4'd2:    a = 20'sd16055;
         4'd3:    a = 20'sd8150;
         4'd4:    a = 20'sd4091;
         4'd5:    a = 20'sd2047;
         4'd6:    a = 20'sd1024;
         4'd7:    a = 20'sd512;
         4'd8:    a = 20'sd256;
         4'd9:    a = 20'sd128;
         4'd10:   a = 20'sd64;
         4'd11:   a = 20'sd32;
         4'd12:   a = 20'sd16;
         4'd13:   a = 20'sd8;
         4'd14:   a = 20'sd4;
         default: a = 20'sd2;
      endcase
      return a;
   endfunction

endpackage

### design/pwpm_ctrl.sv
module pwpm_ctrl
   import pwpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         rsp_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd,
   output logic         req_ready,
   output logic         rsp_valid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT:   if (stat.sweep_last) state_in = S_IDLE;
         S_IDLE:   if (req_valid) state_in = S_DECODE;
         S_DECODE: begin
            if (stat.is_clear) state_in = S_SWEEP;
            else if (stat.quick) state_in = S_FINISH;
            else state_in = S_READ;
         end
         S_SWEEP:  if (stat.sweep_last) state_in = S_FINISH;
         S_READ:   state_in = S_PREP;
         S_PREP:   state_in = S_ITER;
         S_ITER:   if (stat.iter_last) state_in = S_FINISH;
         S_FINISH: state_in = S_RESP;
         S_RESP:   if (rsp_ready) state_in = S_IDLE;
         default:  state_in = S_INIT;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_INIT:   cmd.sweep_step = 1'b1;
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load_req = req_valid;
         end
         S_DECODE: cmd.sweep_start = stat.is_clear;
         S_SWEEP:  cmd.sweep_step = 1'b1;
         S_PREP:   cmd.prep = 1'b1;
         S_ITER:   cmd.iter = 1'b1;
         S_FINISH: cmd.finish = 1'b1;
         S_RESP:   rsp_valid = 1'b1;
         default:  cmd = '0;
      endcase
   end

endmodule

### design/pwpm_dp.sv
module pwpm_dp
   import pwpm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_stat_type         stat,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [8:0]          csr_data,
   input  logic [1:0]          req_cmd,
   input  logic [7:0]          req_pixel_col,
   input  logic [7:0]          req_pixel_row,
   input  logic [15:0]         req_range_in,
   input  logic signed [15:0]  req_bearing_in,
   input  logic signed [23:0]  req_pose_east,
   input  logic signed [23:0]  req_pose_north,
   input  logic signed [15:0]  req_pose_heading,
   output logic [1:0]          rsp_status,
   output logic                rsp_mapped,
   output logic [15:0]         rsp_range_out,
   output logic signed [15:0]  rsp_bearing_out,
   output logic signed [23:0]  rsp_world_east,
   output logic signed [23:0]  rsp_world_north,
   output logic [12:0]         rsp_nearest_dist,
   output logic [12:0]         rsp_farthest_dist,
   output logic [16:0]         rsp_nonzero_count
);

   // configuration
   logic [8:0] width_ff, height_ff;
   logic [7:0] ccol_ff, crow_ff;

   // request
   cmd_type            cmd_ff;
   logic [7:0]         col_ff, row_ff;
   logic [15:0]        rng_ff;
   logic signed [15:0] brg_ff, ph_ff;
   logic signed [23:0] pe_ff, pn_ff;

   // tracked state
   logic [12:0] near_ff, far_ff;
   logic [16:0] count_ff;
   logic [15:0] sweep_ff;

   // table
   logic [31:0] mem [65536];
   logic [31:0] rd_ff;
   logic        mem_we;
   logic [15:0] mem_addr;
   logic [31:0] mem_wdata;
   logic [15:0] idx;

   // iteration
   logic [3:0]          cnt_ff;
   logic                old_zero_ff;
   logic [25:0]         rem_ff, root_ff;
   logic signed [33:0]  x_ff, y_ff;
   logic signed [19:0]  z_ff;
   logic                flip_ff;

   // result
   logic [1:0]         st_ff;
   logic               mapped_ff;
   logic [15:0]        rout_ff;
   logic signed [15:0] bout_ff;
   logic signed [23:0] we_ff, wn_ff;

   logic inb, rng_zero, quick, write_ok;
   logic signed [8:0]  dc, dr;
   logic signed [17:0] dc_sq, dr_sq;
   logic [17:0]        sq;
   logic [4:0]         bit_sh;
   logic [25:0]        bit_val, trial;
   logic signed [17:0] g_sum, g_wrap;
   logic signed [20:0] z_full, z_adj;
   logic [45:0]        prod;
   logic signed [33:0] sx, sy, xf, yf, ce, cn, se, sn;
   logic signed [19:0] at;
   logic [1:0]         st_code;

   function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
      logic signed [23:0] r;
      if (v > POS_MAX) r = 24'sh7FFFFF;
      else if (v < POS_MIN) r = -24'sh800000;
      else r = v[23:0];
      return r;
   endfunction

   assign idx = {row_ff, col_ff};

   always_comb begin
      inb = ({1'b0, col_ff} < width_ff) && ({1'b0, row_ff} < height_ff);
      rng_zero = (rng_ff == 16'd0);
      case (cmd_ff)
         CMD_WRITE:  quick = !inb || rng_zero;
         CMD_LOOKUP: quick = !inb;
         CMD_CLEAR:  quick = 1'b0;
         CMD_NOP:    quick = 1'b1;
         default:    quick = 1'b1;
      endcase
      write_ok = (cmd_ff == CMD_WRITE) && inb && !rng_zero;
      if (!inb && (cmd_ff == CMD_WRITE || cmd_ff == CMD_LOOKUP)) st_code = ST_OUT_BOUND;
      else if (cmd_ff == CMD_WRITE && rng_zero) st_code = ST_ZERO_RNG;
      else st_code = ST_OK;

      stat.is_clear = (cmd_ff == CMD_CLEAR);
      stat.quick = quick;
      stat.iter_last = (cmd_ff == CMD_WRITE) ? (cnt_ff == SQRT_LAST) : (cnt_ff == CORDIC_LAST);
      stat.sweep_last = (sweep_ff == 16'hFFFF);

      // squared distance from center
      dc = $signed({1'b0, col_ff}) - $signed({1'b0, ccol_ff});
      dr = $signed({1'b0, row_ff}) - $signed({1'b0, crow_ff});
      dc_sq = dc * dc;
      dr_sq = dr * dr;
      sq = $unsigned(dc_sq) + $unsigned(dr_sq);

      // one root digit per step
      bit_sh = 5'd24 - {cnt_ff, 1'b0};
      bit_val = 26'd1 << bit_sh;
      trial = root_ff + bit_val;

      // bearing plus heading, wrapped into [-pi, pi]
      g_sum = 18'(rd_ff[31:16]) - 18'sd0;
      g_sum = $signed({{2{rd_ff[31]}}, rd_ff[31:16]}) + $signed({{2{ph_ff[15]}}, ph_ff});
      if (g_sum > PI_Q13) g_wrap = g_sum - TWO_PI_Q13;
      else if (g_sum < -PI_Q13) g_wrap = g_sum + TWO_PI_Q13;
      else g_wrap = g_sum;
      z_full = {g_wrap, 3'b000};
      if (z_full > HALF_Q16) z_adj = z_full - FULL_Q16;
      else if (z_full < -HALF_Q16) z_adj = z_full + FULL_Q16;
      else z_adj = z_full;
      prod = 46'(rd_ff[15:0]) * 46'(CORDIC_GAIN);

      // rotation step
      sx = x_ff >>> cnt_ff;
      sy = y_ff >>> cnt_ff;
      at = atan_q16(cnt_ff);

      // round to Q15.8 and add pose
      xf = flip_ff ? -x_ff : x_ff;
      yf = flip_ff ? -y_ff : y_ff;
      ce = (xf + 34'sd8192) >>> 14;
      cn = (yf + 34'sd8192) >>> 14;
      se = ce + 34'(pe_ff);
      sn = cn + 34'(pn_ff);

      mem_we = cmd.sweep_step || (cmd.finish && write_ok);
      mem_addr = cmd.sweep_step ? sweep_ff : idx;
      mem_wdata = cmd.sweep_step ? 32'd0 : {brg_ff, rng_ff};
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      rd_ff <= mem[idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         ccol_ff   <= 8'd128;
         crow_ff   <= 8'd128;
      end else if (csr_write) begin
         case (csr_type'(csr_index))
            CSR_WIDTH:    width_ff  <= csr_data;
            CSR_HEIGHT:   height_ff <= csr_data;
            CSR_CENTER_C: ccol_ff   <= csr_data[7:0];
            CSR_CENTER_R: crow_ff   <= csr_data[7:0];
            default:      width_ff  <= width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= CMD_NOP;
      end else if (cmd.load_req) begin
         cmd_ff <= cmd_type'(req_cmd);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         col_ff <= req_pixel_col;
         row_ff <= req_pixel_row;
         rng_ff <= req_range_in;
         brg_ff <= req_bearing_in;
         pe_ff  <= req_pose_east;
         pn_ff  <= req_pose_north;
         ph_ff  <= req_pose_heading;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_start) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_step) begin
         sweep_ff <= sweep_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         cnt_ff <= '0;
         old_zero_ff <= (rd_ff[15:0] == 16'd0);
         rem_ff <= {sq, 8'd0};
         root_ff <= '0;
         x_ff <= $signed({4'd0, prod[45:16]});
         y_ff <= '0;
         z_ff <= z_adj[19:0];
         flip_ff <= (z_full > HALF_Q16) || (z_full < -HALF_Q16);
      end else if (cmd.iter) begin
         cnt_ff <= cnt_ff + 4'd1;
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_val;
         end else begin
            root_ff <= root_ff >> 1;
         end
         if (z_ff >= 0) begin
            x_ff <= x_ff - sy;
            y_ff <= y_ff + sx;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + sy;
            y_ff <= y_ff - sx;
            z_ff <= z_ff + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff  <= DIST_ALL_ONES;
         far_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.finish) begin
         if (cmd_ff == CMD_CLEAR) begin
            count_ff <= '0;
         end else if (write_ok) begin
            if (old_zero_ff && count_ff < COUNT_MAX) count_ff <= count_ff + 17'd1;
            if (root_ff[12:0] > far_ff) far_ff <= root_ff[12:0];
            if (root_ff[12:0] < near_ff) near_ff <= root_ff[12:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         st_ff <= st_code;
         if (cmd_ff == CMD_LOOKUP && inb) begin
            mapped_ff <= (rd_ff[15:0] != 16'd0);
            rout_ff <= rd_ff[15:0];
            bout_ff <= rd_ff[31:16];
            we_ff <= sat24(se);
            wn_ff <= sat24(sn);
         end else begin
            mapped_ff <= 1'b0;
            rout_ff <= '0;
            bout_ff <= '0;
            we_ff <= '0;
            wn_ff <= '0;
         end
      end
   end

   assign rsp_status = st_ff;
   assign rsp_mapped = mapped_ff;
   assign rsp_range_out = rout_ff;
   assign rsp_bearing_out = bout_ff;
   assign rsp_world_east = we_ff;
   assign rsp_world_north = wn_ff;
   assign rsp_nearest_dist = near_ff;
   assign rsp_farthest_dist = far_ff;
   assign rsp_nonzero_count = count_ff;

endmodule

### design/pixel_to_world_polar_map_core.sv
// Requests are handled one at a time: a new request is taken only after the last
//   result has been taken. A write runs the 13-step root unit, a lookup the 16-step
//   rotation unit, and a clear sweeps the whole table; a refused or unused command
//   skips these and goes straight to its result.
// Reset: synchronous; afterwards a pass zeroes all 65536 table entries, during
//   which no request is taken (csr writes are taken at any time).
`include "pixel_to_world_polar_map_core_macros.svh"
module pixel_to_world_polar_map_core
   import pwpm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_cmd,
   input  logic [7:0]          req_pixel_col,
   input  logic [7:0]          req_pixel_row,
   input  logic [15:0]         req_range_in,
   input  logic signed [15:0]  req_bearing_in,
   input  logic signed [23:0]  req_pose_east,
   input  logic signed [23:0]  req_pose_north,
   input  logic signed [15:0]  req_pose_heading,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic                rsp_mapped,
   output logic [15:0]         rsp_range_out,
   output logic signed [15:0]  rsp_bearing_out,
   output logic signed [23:0]  rsp_world_east,
   output logic signed [23:0]  rsp_world_north,
   output logic [12:0]         rsp_nearest_dist,
   output logic [12:0]         rsp_farthest_dist,
   output logic [16:0]         rsp_nonzero_count,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [8:0]          csr_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // csr writes land directly in the config registers
   assign csr_ready = 1'b1;

   // sequencer: init sweep, decode, table read or clear sweep, prep, iterate, finish, hold result
   pwpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid)
   );

   // table, root unit, rotation unit, tracked distances and count
   pwpm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_cmd           (req_cmd),
      .req_pixel_col     (req_pixel_col),
      .req_pixel_row     (req_pixel_row),
      .req_range_in      (req_range_in),
      .req_bearing_in    (req_bearing_in),
      .req_pose_east     (req_pose_east),
      .req_pose_north    (req_pose_north),
      .req_pose_heading  (req_pose_heading),
      .rsp_status        (rsp_status),
      .rsp_mapped        (rsp_mapped),
      .rsp_range_out     (rsp_range_out),
      .rsp_bearing_out   (rsp_bearing_out),
      .rsp_world_east    (rsp_world_east),
      .rsp_world_north   (rsp_world_north),
      .rsp_nearest_dist  (rsp_nearest_dist),
      .rsp_farthest_dist (rsp_farthest_dist),
      .rsp_nonzero_count (rsp_nonzero_count)
   );

   // a result on hold blocks new requests
   `PWPM_ASSERT_SAME(a_rsp_blocks_req, clock, reset, rsp_valid, !req_ready)
   // a transfer starts work at once
   `PWPM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // table holds 65536 entries at most
   `PWPM_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, rsp_nonzero_count <= 17'd65536)
   // a mapped lookup carries a range and ok status
   `PWPM_ASSERT_SAME(a_mapped_range, clock, reset, rsp_valid && rsp_mapped,
      rsp_range_out != 16'd0 && rsp_status == ST_OK)

endmodule
